FILE: rtl/core/modexp_pkg.sv
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared types for the modular exponentiation block: controller states and
// the command / status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package modexp_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_CHECK,
    S_MUL_RES,
    S_MUL_SQR,
    S_FINISH
  } modexp_state_t;

  typedef struct packed {
    logic load;      // capture operands from the input beat
    logic red_step;  // one restoring step of base % modulus
    logic mul_start; // clear accumulator, latch multiplier bits
    logic mul_step;  // one shift-add step of the modular product
    logic sel_sqr;   // 0: res * b, 1: b * b
    logic commit;    // write the finished product back
    logic out_load;  // move the result into the output register
  } modexp_cmd_t;

  typedef struct packed {
    logic cnt_last;  // bit counter at its final step
    logic trivial;   // zero exponent or zero modulus
    logic exp_zero;  // no exponent bits left
    logic exp_bit0;  // current exponent bit
  } modexp_sts_t;

endpackage

FILE: rtl/core/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base^exponent mod modulus by right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// One beat in, one beat out. The block works on one item at a time; the base
// reduction runs through a restoring remainder unit and every product through
// one shift-add modular multiplier that retires one multiplier bit per cycle.
// A zero exponent or zero modulus skips the reduction and the products. A zero
// exponent returns 1 regardless of modulus. The output register lets the next
// item be accepted while the previous result waits on out_stall.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int OPERAND_BITS = 31
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OPERAND_BITS-1:0] in_base_value,
  input  logic [OPERAND_BITS-1:0] in_exponent,
  input  logic [OPERAND_BITS-1:0] in_modulus,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [OPERAND_BITS-1:0] out_power_result
);
  import modexp_pkg::*;

  modexp_cmd_t             cmd;
  modexp_sts_t             sts;
  logic [OPERAND_BITS-1:0] res_value;
  logic                    out_free;
  logic                    out_valid_r;
  logic [OPERAND_BITS-1:0] out_power_result_r;

  modexp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  modexp_dp #(
    .OPERAND_BITS (OPERAND_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_base_value (in_base_value),
    .in_exponent   (in_exponent),
    .in_modulus    (in_modulus),
    .res_value     (res_value)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_power_result_r <= res_value;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_power_result = out_power_result_r;

endmodule

FILE: rtl/core/modexp_dp.sv
// ----------------------------------------------------------------------------
// modexp_dp
// Datapath: operand registers, restoring remainder unit for the initial base
// reduction and a bit-serial shift-add modular multiplier.
// ----------------------------------------------------------------------------
module modexp_dp #(
  parameter int OPERAND_BITS = 31
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  modexp_pkg::modexp_cmd_t cmd,
  output modexp_pkg::modexp_sts_t sts,
  input  logic [OPERAND_BITS-1:0] in_base_value,
  input  logic [OPERAND_BITS-1:0] in_exponent,
  input  logic [OPERAND_BITS-1:0] in_modulus,
  output logic [OPERAND_BITS-1:0] res_value
);
  import modexp_pkg::*;

  localparam int W  = OPERAND_BITS;
  localparam int CW = $clog2(OPERAND_BITS);

  logic [W-1:0]  div_r;
  logic [W-1:0]  b_r;
  logic [W-1:0]  exp_r;
  logic [W-1:0]  mod_r;
  logic [W-1:0]  res_r;
  logic [W-1:0]  acc_r;
  logic [W-1:0]  mulq_r;
  logic [CW-1:0] cnt_r;

  logic [W:0]    red_t;
  logic [W-1:0]  red_nxt;
  logic [W-1:0]  mul_a;
  logic [W+1:0]  mul_s;
  logic [W+1:0]  m1;
  logic [W+1:0]  m2;
  logic [W+1:0]  mul_red;
  logic [W-1:0]  acc_nxt;
  logic [W-1:0]  res_init;

  // restoring remainder step: shift in next dividend bit, subtract if it fits
  always_comb begin
    red_t = {b_r, div_r[W-1]};
    if (red_t >= {1'b0, mod_r}) begin
      red_nxt = W'(red_t - {1'b0, mod_r});
    end else begin
      red_nxt = red_t[W-1:0];
    end
  end

  // acc*2 + a*bit lies below 3*m; pick among s, s-m, s-2m
  always_comb begin
    mul_a = cmd.sel_sqr ? b_r : res_r;
    mul_s = {1'b0, acc_r, 1'b0} + {2'b00, mul_a & {W{mulq_r[W-1]}}};
    m1    = {2'b00, mod_r};
    m2    = {1'b0, mod_r, 1'b0};
    if (mul_s >= m2) begin
      mul_red = mul_s - m2;
    end else if (mul_s >= m1) begin
      mul_red = mul_s - m1;
    end else begin
      mul_red = mul_s;
    end
    acc_nxt = mul_red[W-1:0];
  end

  // zero exponent gives 1; a modulus of one or zero gives 0 otherwise
  always_comb begin
    if (in_exponent == '0) begin
      res_init = W'(1);
    end else if (in_modulus <= W'(1)) begin
      res_init = '0;
    end else begin
      res_init = W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= '0;
    end else if (cmd.red_step || cmd.mul_step) begin
      if (sts.cnt_last) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      div_r <= in_base_value;
      b_r   <= '0;
      exp_r <= in_exponent;
      mod_r <= in_modulus;
      res_r <= res_init;
    end
    if (cmd.red_step) begin
      b_r   <= red_nxt;
      div_r <= {div_r[W-2:0], 1'b0};
    end
    // start wins over the step so a commit can chain into the next product
    if (cmd.mul_start) begin
      acc_r  <= '0;
      mulq_r <= b_r;
    end else if (cmd.mul_step) begin
      acc_r  <= acc_nxt;
      mulq_r <= {mulq_r[W-2:0], 1'b0};
    end
    if (cmd.commit) begin
      if (cmd.sel_sqr) begin
        b_r   <= acc_nxt;
        exp_r <= exp_r >> 1;
      end else begin
        res_r <= acc_nxt;
      end
    end
  end

  always_comb begin
    sts.cnt_last = (cnt_r == CW'(W - 1));
    sts.trivial  = (exp_r == '0) || (mod_r == '0);
    sts.exp_zero = (exp_r == '0);
    sts.exp_bit0 = exp_r[0];
  end

  assign res_value = res_r;

  a_res_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && !cmd.sel_sqr |=> res_r < mod_r)
    else $error("result product not reduced");

  a_base_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && cmd.sel_sqr |=> b_r < mod_r)
    else $error("squared base not reduced");

endmodule

FILE: rtl/core/modexp_ctrl.sv
// ----------------------------------------------------------------------------
// modexp_ctrl
// Controller: sequences base reduction, then per exponent bit an optional
// result product and a squaring, then hands the result to the output stage.
// ----------------------------------------------------------------------------
module modexp_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    out_free,
  input  modexp_pkg::modexp_sts_t sts,
  output modexp_pkg::modexp_cmd_t cmd
);
  import modexp_pkg::*;

  modexp_state_t state_r;
  modexp_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_REDUCE;
      end
      S_REDUCE: begin
        if (sts.trivial) begin
          state_nxt = S_FINISH;
        end else if (sts.cnt_last) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.exp_zero) begin
          state_nxt = S_FINISH;
        end else if (sts.exp_bit0) begin
          state_nxt = S_MUL_RES;
        end else begin
          state_nxt = S_MUL_SQR;
        end
      end
      S_MUL_RES: begin
        if (sts.cnt_last) state_nxt = S_MUL_SQR;
      end
      S_MUL_SQR: begin
        if (sts.cnt_last) state_nxt = S_CHECK;
      end
      S_FINISH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_REDUCE: begin
        cmd.red_step = !sts.trivial;
      end
      S_CHECK: begin
        cmd.mul_start = !sts.exp_zero;
      end
      S_MUL_RES: begin
        cmd.mul_step = 1'b1;
        if (sts.cnt_last) begin
          cmd.commit    = 1'b1;
          cmd.mul_start = 1'b1;
        end
      end
      S_MUL_SQR: begin
        cmd.mul_step = 1'b1;
        cmd.sel_sqr  = 1'b1;
        cmd.commit   = sts.cnt_last;
      end
      S_FINISH: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_load_reduce: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_REDUCE)
    else $error("accepted beat did not start reduction");

  a_commit_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.cnt_last && (state_r == S_MUL_RES || state_r == S_MUL_SQR))
    else $error("product committed before its last step");

endmodule

FILE: bench/tb_modular_exponentiation.sv
// ----------------------------------------------------------------------------
// tb_modular_exponentiation
// Self-checking bench for the square-and-multiply modular exponentiation
// block. A behavioral model predicts base^exponent mod modulus for every
// accepted input beat, and the results are checked in order. The run covers
// directed corner cases, weighted random operands, a long output hold-off,
// a drain pause and a steady stream. Random idle bursts on both channels are
// part of the run.
module tb_modular_exponentiation;

  localparam int W              = 31;
  localparam int WATCHDOG_LIMIT = 12000;  // worst-case item plus hold-off
  localparam int HOLDOFF_CYCLES = 400;
  localparam int TAIL_CYCLES    = 2100;   // one worst-case item latency
  localparam logic [W-1:0] ALL_ONES = '1;

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_stall;
  logic [W-1:0] in_base_value;
  logic [W-1:0] in_exponent;
  logic [W-1:0] in_modulus;
  logic         out_valid;
  logic         out_stall;
  logic [W-1:0] out_power_result;

  logic [W-1:0] pending_powers[$];
  int           fail_count;
  int           sent_count;
  int           checked_count;
  int           zero_exp_count;
  int           unit_mod_count;
  int           wide_exp_count;
  int           quiet_cycles;
  int           hold_request;
  bit           send_idle_on;
  bit           recv_idle_on;

  modular_exponentiation #(.OPERAND_BITS(W)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_base_value    (in_base_value),
    .in_exponent      (in_exponent),
    .in_modulus       (in_modulus),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_power_result (out_power_result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Right-to-left square-and-multiply on 64-bit integers; operands are
  // below 2^31 so every product fits.
  function automatic logic [W-1:0] predict_power(input logic [W-1:0] b,
                                                  input logic [W-1:0] e,
                                                  input logic [W-1:0] m);
    longint unsigned acc;
    longint unsigned sq;
    longint unsigned mm;
    logic [W-1:0]    bits;
    mm = m;
    bits = e;
    if (e == '0) return W'(1);   // even for a unit modulus
    if (m == '0) return '0;
    acc = 1 % mm;
    sq = b % mm;
    while (bits != '0) begin
      if (bits[0]) acc = (acc * sq) % mm;
      sq = (sq * sq) % mm;
      bits = bits >> 1;
    end
    return acc[W-1:0];
  endfunction

  function automatic logic [W-1:0] rand_operand(input int max_bits);
    int           k;
    logic [W-1:0] v;
    k = $urandom_range(0, max_bits);
    v = W'($urandom);
    return v & (ALL_ONES >> (W - k));
  endfunction

  task automatic send_operands(input logic [W-1:0] b, input logic [W-1:0] e,
                               input logic [W-1:0] m);
    int gap;
    @(negedge clk);
    if (send_idle_on && $urandom_range(0, 99) < 20) begin
      gap = $urandom_range(1, 14);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_base_value = b;
    in_exponent   = e;
    in_modulus    = m;
    in_valid      = 1'b1;
    do @(posedge clk); while (in_stall);
    pending_powers.push_back(predict_power(b, e, m));
    sent_count++;
    if (e == '0) zero_exp_count++;
    if (m == W'(1)) unit_mod_count++;
    if (e[W-1]) wide_exp_count++;
  endtask

  // Lower valid, then wait for every predicted result to be checked.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_powers.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_operands('0, '0, W'(1));              // zero exponent, unit modulus
    send_operands(W'(5), '0, W'(7));
    send_operands(ALL_ONES, '0, ALL_ONES);
    send_operands(W'(7), W'(5), W'(1));        // unit modulus gives zero
    send_operands(ALL_ONES, ALL_ONES, W'(1));
    send_operands('0, W'(5), W'(13));          // zero base
    send_operands('0, ALL_ONES, ALL_ONES);
    send_operands(ALL_ONES, ALL_ONES, ALL_ONES);
    send_operands(ALL_ONES, W'(1), ALL_ONES - W'(1));
    send_operands(ALL_ONES - W'(1), ALL_ONES, ALL_ONES);
    send_operands(W'(2), W'(30), ALL_ONES);
    send_operands(W'(3), W'(1), ALL_ONES);
    send_operands(W'(123456789), W'(1), W'(1000));
    send_operands(ALL_ONES, ALL_ONES, W'(2));
    send_operands(W'(1), ALL_ONES, ALL_ONES);
    send_operands(W'(2), W'(32'h4000_0000), W'(1000000007));
    send_operands(W'(32'h5555_5555), W'(32'h2AAA_AAAA), W'(32'h7FFF_FFED));
    send_operands(W'(32'h2AAA_AAAA), W'(32'h5555_5555), W'(32'h5555_5555));
    send_operands(ALL_ONES, W'(2), W'(32'h4000_0000));
    send_operands(W'(32'h4000_0000), W'(3), W'(32'h4000_0001));
    drain_results();
  endtask

  task automatic test_random(input int count);
    logic [W-1:0] b;
    logic [W-1:0] e;
    logic [W-1:0] m;
    for (int i = 0; i < count; i++) begin
      if (i % 30 == 0) begin
        send_idle_on = ($urandom_range(0, 3) != 0);
        recv_idle_on = ($urandom_range(0, 3) != 0);
      end
      case ($urandom_range(0, 9))
        0:       b = ALL_ONES;
        1:       b = rand_operand(8);
        default: b = rand_operand(W);
      endcase
      // mostly short exponents keep the run time down
      case ($urandom_range(0, 9))
        0:       e = '0;
        1:       e = W'($urandom);
        2:       e = ALL_ONES;
        default: e = rand_operand(12);
      endcase
      case ($urandom_range(0, 9))
        0:       m = W'(1);
        1:       m = ALL_ONES;
        2:       m = W'($urandom_range(1, 255));
        default: m = rand_operand(W);
      endcase
      if (m == '0) m = W'(1);
      send_operands(b, e, m);
    end
    drain_results();
  endtask

  // Receiver holds off while the sender keeps offering quick beats, so the
  // output register fills and the input stalls.
  task automatic test_output_holdoff();
    send_idle_on = 1'b0;
    hold_request = HOLDOFF_CYCLES;
    for (int i = 0; i < 10; i++)
      send_operands(rand_operand(W), (i % 2 == 0) ? '0 : rand_operand(3),
                    ALL_ONES - W'(i));
    drain_results();
    send_idle_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 5; i++)
      send_operands(rand_operand(W), rand_operand(6), W'($urandom_range(1, 1000)));
    drain_results();
    for (int i = 0; i < 5; i++)
      send_operands(rand_operand(W), rand_operand(6), rand_operand(W) | W'(1));
    drain_results();
  endtask

  task automatic test_steady_stream(input int count);
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    for (int i = 0; i < count; i++)
      send_operands(rand_operand(W), rand_operand(10), rand_operand(W) | W'(1));
    drain_results();
  endtask

  // Result side: random stall bursts, plus the requested long hold-off.
  initial begin
    int hold_left;
    int burst_left;
    hold_left = 0;
    burst_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall = 1'b1;
      end else if (recv_idle_on && $urandom_range(0, 99) < 15) begin
        burst_left = $urandom_range(1, 14) - 1;
        out_stall = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_powers.size() == 0) begin
        $error("power_result: expected none, got %0d", out_power_result);
        fail_count++;
      end else begin
        if (out_power_result !== pending_powers[0]) begin
          $error("power_result: expected %0d, got %0d", pending_powers[0],
                 out_power_result);
          fail_count++;
        end
        void'(pending_powers.pop_front());
        checked_count++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_base_value = '0;
    in_exponent   = '0;
    in_modulus    = W'(1);
    hold_request  = 0;
    send_idle_on  = 1'b1;
    recv_idle_on  = 1'b1;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(230);
    test_output_holdoff();
    test_drain_pause();
    test_steady_stream(25);

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d beats: %0d zero exponents, %0d unit moduli, %0d full-width exponents.",
             sent_count, zero_exp_count, unit_mod_count, wide_exp_count);
    $display("Checked %0d results with %0d mismatches.", checked_count, fail_count);
    if (fail_count == 0 && pending_powers.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
